// ----- rtl/pwmm_pkg.sv -----
// Shared types and constants of the PWM edge timestamp meter.
package pwmm_pkg;

  // Timer wraps after CounterTop, so one overflow is worth CounterTop+1 ticks.
  localparam int unsigned CounterTop    = 65535;
  localparam int unsigned TopPlusOne    = CounterTop + 1;

  localparam int unsigned StampW        = 16;
  localparam int unsigned OvfW          = 16;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned TickRateW     = 24;
  localparam int unsigned DutyW         = 7;
  localparam int unsigned SumW          = TimeW + 1;
  localparam int unsigned ProdW         = TimeW + DutyW;
  localparam int unsigned StepCntW      = 5;

  localparam logic [TickRateW-1:0] TickRateReset = 24'd1000000;
  localparam logic [DutyW-1:0]     PercentScale  = 7'd100;

  // Event kinds.
  localparam logic FuncEdge     = 1'b0;
  localparam logic FuncOverflow = 1'b1;

  // Measurement phases.
  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhaseHigh = 2'd1;
  localparam logic [1:0] PhaseLow  = 2'd2;

  // Register map.
  localparam int unsigned   PaddrW       = 3;
  localparam logic          RegTickRate  = 1'b0;

  // Job handed from front to back: times after the item plus the measured flag.
  typedef struct packed {
    logic [TimeW-1:0] high;
    logic [TimeW-1:0] low;
    logic             both;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_FREQ = 4'b0010,
    B_DUTY = 4'b0100,
    B_DONE = 4'b1000
  } back_state_t;

endpackage

// ----- rtl/pwmm_front.sv -----
// Front end: accepts events, tracks edges and overflows, emits one job per item.
module pwmm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             func,
  input  logic [pwmm_pkg::StampW-1:0]      capture,
  output pwmm_pkg::job_t                   job
);

  logic [1:0]                      phase;
  logic [pwmm_pkg::StampW-1:0]     last_stamp;
  logic [pwmm_pkg::OvfW-1:0]       overflow_count;
  logic [pwmm_pkg::TimeW-1:0]      high_ticks;
  logic [pwmm_pkg::TimeW-1:0]      low_ticks;
  logic                            both_measured;

  logic [1:0]                      phase_next;
  logic [pwmm_pkg::StampW-1:0]     last_stamp_next;
  logic [pwmm_pkg::OvfW-1:0]       overflow_count_next;
  logic [pwmm_pkg::TimeW-1:0]      high_ticks_next;
  logic [pwmm_pkg::TimeW-1:0]      low_ticks_next;
  logic                            both_measured_next;

  logic [32:0]                     ovf_ticks;
  logic signed [34:0]              span;
  logic [pwmm_pkg::TimeW-1:0]      interval;

  // stamp - last + overflows*(TOP+1), clamped to [0, 2^32-1]
  always_comb begin
    ovf_ticks = 33'(overflow_count) * 33'(pwmm_pkg::TopPlusOne);
    span      = signed'({2'b00, ovf_ticks}) + signed'(35'(capture))
                - signed'(35'(last_stamp));
    if (span[34]) begin
      interval = '0;
    end else if (span[33:32] != 2'b00) begin
      interval = '1;
    end else begin
      interval = span[31:0];
    end
  end

  always_comb begin
    phase_next          = phase;
    last_stamp_next     = last_stamp;
    overflow_count_next = overflow_count;
    high_ticks_next     = high_ticks;
    low_ticks_next      = low_ticks;
    both_measured_next  = both_measured;
    if (func == pwmm_pkg::FuncOverflow) begin
      if (overflow_count != '1) begin
        overflow_count_next = overflow_count + 1'b1;
      end
    end else begin
      last_stamp_next     = capture;
      overflow_count_next = '0;
      case (phase)
        pwmm_pkg::PhaseHigh: begin
          high_ticks_next = interval;
          phase_next      = pwmm_pkg::PhaseLow;
        end
        pwmm_pkg::PhaseLow: begin
          low_ticks_next     = interval;
          both_measured_next = 1'b1;
          phase_next         = pwmm_pkg::PhaseHigh;
        end
        default: begin
          // first edge, or the unused code: restart
          phase_next = pwmm_pkg::PhaseHigh;
        end
      endcase
    end
  end

  assign job.high = high_ticks_next;
  assign job.low  = low_ticks_next;
  assign job.both = both_measured_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pwmm_pkg::PhaseIdle;
      last_stamp     <= '0;
      overflow_count <= '0;
      high_ticks     <= '0;
      low_ticks      <= '0;
      both_measured  <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      last_stamp     <= last_stamp_next;
      overflow_count <= overflow_count_next;
      high_ticks     <= high_ticks_next;
      low_ticks      <= low_ticks_next;
      both_measured  <= both_measured_next;
    end
  end

endmodule

// ----- rtl/pwmm_queue.sv -----
// Two-entry job queue between front and back.
module pwmm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pwmm_pkg::job_t     push_job,
  input  logic               pop,
  output pwmm_pkg::job_t     head_job,
  output pwmm_pkg::q_status_t status
);

  pwmm_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign head_job     = entries[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/pwmm_back.sv -----
// Back end: shared restoring divider for frequency and duty, plus result register.
module pwmm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pwmm_pkg::TickRateW-1:0]    tick_rate,
  input  pwmm_pkg::q_status_t               q_status,
  input  pwmm_pkg::job_t                    head_job,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [pwmm_pkg::TimeW-1:0]        high_time,
  output logic [pwmm_pkg::TimeW-1:0]        low_time,
  output logic [pwmm_pkg::TickRateW-1:0]    frequency,
  output logic [pwmm_pkg::DutyW-1:0]        duty_percent,
  output logic                              measure_valid
);

  pwmm_pkg::back_state_t            state;
  logic [pwmm_pkg::TimeW-1:0]       hi;
  logic [pwmm_pkg::TimeW-1:0]       lo;
  logic [pwmm_pkg::SumW-1:0]        sum;
  logic                             ok;
  logic [pwmm_pkg::ProdW-1:0]       prod;
  logic [pwmm_pkg::SumW-1:0]        rem;
  logic [pwmm_pkg::TickRateW-1:0]   dvd;
  logic [pwmm_pkg::TickRateW-1:0]   quo;
  logic [pwmm_pkg::TickRateW-1:0]   freq_q;
  logic [pwmm_pkg::StepCntW-1:0]    cnt;

  logic [pwmm_pkg::SumW-1:0]        head_sum;
  logic                             head_ok;
  logic [pwmm_pkg::SumW:0]          trial;
  logic [pwmm_pkg::SumW:0]          diff;
  logic                             q_bit;
  logic [pwmm_pkg::SumW-1:0]        rem_next;
  logic [pwmm_pkg::TickRateW-1:0]   quo_next;
  logic                             out_free;

  assign head_sum = pwmm_pkg::SumW'(head_job.high) + pwmm_pkg::SumW'(head_job.low);
  assign head_ok  = head_job.both && (head_sum != '0);
  assign pop      = (state == pwmm_pkg::B_IDLE) && !q_status.empty;
  assign out_free = !result_valid || !result_stall;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem, dvd[pwmm_pkg::TickRateW-1]};
    diff     = trial - {1'b0, sum};
    q_bit    = !diff[pwmm_pkg::SumW];
    rem_next = q_bit ? diff[pwmm_pkg::SumW-1:0] : trial[pwmm_pkg::SumW-1:0];
    quo_next = {quo[pwmm_pkg::TickRateW-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    prod <= pwmm_pkg::ProdW'(hi) * pwmm_pkg::ProdW'(pwmm_pkg::PercentScale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwmm_pkg::B_IDLE;
    end else begin
      case (state)
        pwmm_pkg::B_IDLE: begin
          if (!q_status.empty) begin
            state <= head_ok ? pwmm_pkg::B_FREQ : pwmm_pkg::B_DONE;
          end
        end
        pwmm_pkg::B_FREQ: begin
          if (cnt == pwmm_pkg::StepCntW'(1)) begin
            state <= pwmm_pkg::B_DUTY;
          end
        end
        pwmm_pkg::B_DUTY: begin
          if (cnt == pwmm_pkg::StepCntW'(1)) begin
            state <= pwmm_pkg::B_DONE;
          end
        end
        pwmm_pkg::B_DONE: begin
          if (out_free) begin
            state <= pwmm_pkg::B_IDLE;
          end
        end
        default: state <= pwmm_pkg::B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      pwmm_pkg::B_IDLE: begin
        hi     <= head_job.high;
        lo     <= head_job.low;
        sum    <= head_sum;
        ok     <= head_ok;
        rem    <= '0;
        dvd    <= tick_rate;
        quo    <= '0;
        freq_q <= '0;
        cnt    <= pwmm_pkg::StepCntW'(pwmm_pkg::TickRateW);
      end
      pwmm_pkg::B_FREQ: begin
        if (cnt == pwmm_pkg::StepCntW'(1)) begin
          // duty quotient is below 128, so prod>>7 already sits below sum
          freq_q <= quo_next;
          rem    <= pwmm_pkg::SumW'(prod >> pwmm_pkg::DutyW);
          dvd    <= {prod[pwmm_pkg::DutyW-1:0],
                     (pwmm_pkg::TickRateW-pwmm_pkg::DutyW)'(0)};
          quo    <= '0;
          cnt    <= pwmm_pkg::StepCntW'(pwmm_pkg::DutyW);
        end else begin
          rem <= rem_next;
          dvd <= dvd << 1;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
        end
      end
      pwmm_pkg::B_DUTY: begin
        rem <= rem_next;
        dvd <= dvd << 1;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == pwmm_pkg::B_DONE) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pwmm_pkg::B_DONE) && out_free) begin
      high_time     <= hi;
      low_time      <= lo;
      frequency     <= ok ? freq_q : '0;
      duty_percent  <= ok ? quo[pwmm_pkg::DutyW-1:0] : '0;
      measure_valid <= ok;
    end
  end

endmodule

// ----- rtl/pwm_edge_timestamp_meter.sv -----
// Top level of the PWM edge timestamp meter: config port, front, queue, back.
// For a full period an accepted item is queued, popped, run through 24 frequency
//   and 7 duty divider steps, then loaded into the result register; otherwise the
//   divider is skipped. The bit-serial divider sets the rate: the back pops a new
//   job only after the last result; the two-entry queue lets the front run ahead.
// Reset (rst, synchronous): phase, stamps, counts and times go to zero,
//   tick_rate_hz to 1000000, queue and result register empty.
module pwm_edge_timestamp_meter (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwmm_pkg::PaddrW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // event items
  input  logic                               event_valid,
  output logic                               event_stall,
  input  logic                               func,
  input  logic [pwmm_pkg::StampW-1:0]        capture,
  // result items
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [pwmm_pkg::TimeW-1:0]         high_time,
  output logic [pwmm_pkg::TimeW-1:0]         low_time,
  output logic [pwmm_pkg::TickRateW-1:0]     frequency,
  output logic [pwmm_pkg::DutyW-1:0]         duty_percent,
  output logic                               measure_valid
);

  logic [pwmm_pkg::TickRateW-1:0] tick_rate_hz;
  logic                           reg_sel;
  logic                           ev_accept;
  logic                           pop;
  pwmm_pkg::job_t                 front_job;
  pwmm_pkg::job_t                 head_job;
  pwmm_pkg::q_status_t            q_status;

  // Register map: one register, word index taken from paddr[2].
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == pwmm_pkg::RegTickRate);
  assign prdata  = reg_sel ? 32'(tick_rate_hz) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= pwmm_pkg::TickRateReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tick_rate_hz <= pwdata[pwmm_pkg::TickRateW-1:0];
    end
  end

  // Front stalls only when the job queue is full.
  assign event_stall = q_status.full;
  assign ev_accept   = event_valid && !event_stall;

  pwmm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (ev_accept),
    .func    (func),
    .capture (capture),
    .job     (front_job)
  );

  pwmm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (ev_accept),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Reads tick_rate_hz live; user must change it only when idle; not enforced.
  pwmm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tick_rate     (tick_rate_hz),
    .q_status      (q_status),
    .head_job      (head_job),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .high_time     (high_time),
    .low_time      (low_time),
    .frequency     (frequency),
    .duty_percent  (duty_percent),
    .measure_valid (measure_valid)
  );

endmodule
